@@ rtl/pqss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pqss_pkg;

    localparam int HANDLE_W      = 8;
    localparam int PRIO_W        = 8;
    localparam int COUNT_OUT_W   = 5;
    localparam int ENTRY_W       = HANDLE_W + PRIO_W;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ rtl/priority_queue_scan_select_top.sv @@
// Channel   | Direction | Handshake                    | Ports
// ----------+-----------+------------------------------+-------------------------------------
// command   | in        | start high while busy low    | opcode, item_handle, item_priority
// result    | out       | done high for one cycle      | status, out_handle, out_priority,
//           |           |                              | entry_count, queue_empty
// mode      | in        | cfg_we high                  | cfg_wdata
//
// An insert, or any word that finds the queue full or empty, shows its result in the cycle after
// it is taken and busy never rises. A remove scans all entries for the winner, then moves each
// entry after the winning slot down one slot to close the gap, with no moves when the last entry
// wins; the single read port of the slot memory has both steps read the slots one at a time.
// Reset clears the fill count and the mode; the slot memory is not cleared. The receiver cannot
// stall: each result word lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_scan_select_top #(
    parameter int DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                opcode,
    input  wire logic [pqss_pkg::HANDLE_W-1:0]       item_handle,
    input  wire logic [pqss_pkg::PRIO_W-1:0]         item_priority,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_wdata,
    output logic                                     done,
    output logic [1:0]                               status,
    output logic [pqss_pkg::HANDLE_W-1:0]            out_handle,
    output logic [pqss_pkg::PRIO_W-1:0]              out_priority,
    output logic [pqss_pkg::COUNT_OUT_W-1:0]         entry_count,
    output logic                                     queue_empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            mode_reg;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [IW-1:0]                   best_idx_reg, best_idx_next;
    logic [pqss_pkg::HANDLE_W-1:0]   best_handle_reg, best_handle_next;
    logic [pqss_pkg::PRIO_W-1:0]     best_prio_reg, best_prio_next;
    logic                            first_reg, first_next;
    logic                            pend_reg, pend_next;
    logic [IW-1:0]                   wr_idx_reg, wr_idx_next;

    logic                            done_reg, done_next;
    pqss_pkg::status_t               status_reg, status_next;
    logic [pqss_pkg::HANDLE_W-1:0]   out_handle_reg, out_handle_next;
    logic [pqss_pkg::PRIO_W-1:0]     out_priority_reg, out_priority_next;
    logic [pqss_pkg::COUNT_OUT_W-1:0] entry_count_reg, entry_count_next;
    logic                            queue_empty_reg, queue_empty_next;

    logic [pqss_pkg::ENTRY_W-1:0]    slot_reg [DEPTH];
    logic [pqss_pkg::ENTRY_W-1:0]    rd_data_reg;
    logic [IW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    logic [pqss_pkg::ENTRY_W-1:0]    wr_data;

    logic [pqss_pkg::HANDLE_W-1:0]   rd_handle;
    logic [pqss_pkg::PRIO_W-1:0]     rd_prio;
    logic                            take_new;
    logic [IW-1:0]                   cand_idx;
    logic [IW-1:0]                   win_idx;
    logic [CW-1:0]                   count_dec;

    assign rd_handle = rd_data_reg[pqss_pkg::ENTRY_W-1:pqss_pkg::PRIO_W];
    assign rd_prio   = rd_data_reg[pqss_pkg::PRIO_W-1:0];
    assign cand_idx  = IW'(idx_reg - ONE_C);
    assign take_new  = first_reg ||
                       (mode_reg ? (rd_prio > best_prio_reg) : (rd_prio < best_prio_reg));
    assign win_idx   = take_new ? cand_idx : best_idx_reg;
    assign count_dec = count_reg - ONE_C;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_reg[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        best_idx_next     = best_idx_reg;
        best_handle_next  = best_handle_reg;
        best_prio_next    = best_prio_reg;
        first_next        = first_reg;
        pend_next         = 1'b0;
        wr_idx_next       = wr_idx_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        out_handle_next   = out_handle_reg;
        out_priority_next = out_priority_reg;
        entry_count_next  = entry_count_reg;
        queue_empty_next  = queue_empty_reg;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = wr_idx_reg;
        wr_data           = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    out_handle_next   = '0;
                    out_priority_next = '0;
                    if (opcode == pqss_pkg::OP_INSERT)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            status_next = pqss_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = pqss_pkg::ST_OK;
                            wr_en       = 1'b1;
                            wr_addr     = IW'(count_reg);
                            wr_data     = {item_handle, item_priority};
                            count_next  = count_reg + ONE_C;
                        end
                        done_next        = 1'b1;
                        entry_count_next = pqss_pkg::COUNT_OUT_W'(count_next);
                        queue_empty_next = (count_next == '0);
                    end
                    else if (count_reg == '0)
                    begin
                        status_next      = pqss_pkg::ST_EMPTY;
                        done_next        = 1'b1;
                        entry_count_next = '0;
                        queue_empty_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        idx_next   = ONE_C;
                        first_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                first_next = 1'b0;
                if (take_new)
                begin
                    best_idx_next    = cand_idx;
                    best_handle_next = rd_handle;
                    best_prio_next   = rd_prio;
                end
                if (idx_reg < count_reg)
                begin
                    rd_addr  = IW'(idx_reg);
                    idx_next = idx_reg + ONE_C;
                end
                else
                begin
                    idx_next   = CW'(win_idx) + ONE_C;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Reads run one slot ahead of the write that closes the gap.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wr_idx_reg;
                    wr_data = rd_data_reg;
                end
                if (idx_reg < count_reg)
                begin
                    rd_addr     = IW'(idx_reg);
                    pend_next   = 1'b1;
                    wr_idx_next = IW'(idx_reg - ONE_C);
                    idx_next    = idx_reg + ONE_C;
                end
                else if (!pend_reg)
                begin
                    count_next        = count_dec;
                    done_next         = 1'b1;
                    status_next       = pqss_pkg::ST_OK;
                    out_handle_next   = best_handle_reg;
                    out_priority_next = best_prio_reg;
                    entry_count_next  = pqss_pkg::COUNT_OUT_W'(count_dec);
                    queue_empty_next  = (count_dec == '0);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            mode_reg         <= 1'b0;
            first_reg        <= 1'b0;
            pend_reg         <= 1'b0;
            done_reg         <= 1'b0;
            idx_reg          <= '0;
            best_idx_reg     <= '0;
            best_handle_reg  <= '0;
            best_prio_reg    <= '0;
            wr_idx_reg       <= '0;
            status_reg       <= pqss_pkg::ST_OK;
            out_handle_reg   <= '0;
            out_priority_reg <= '0;
            entry_count_reg  <= '0;
            queue_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            first_reg        <= first_next;
            pend_reg         <= pend_next;
            done_reg         <= done_next;
            idx_reg          <= idx_next;
            best_idx_reg     <= best_idx_next;
            best_handle_reg  <= best_handle_next;
            best_prio_reg    <= best_prio_next;
            wr_idx_reg       <= wr_idx_next;
            status_reg       <= status_next;
            out_handle_reg   <= out_handle_next;
            out_priority_reg <= out_priority_next;
            entry_count_reg  <= entry_count_next;
            queue_empty_reg  <= queue_empty_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_handle   = out_handle_reg;
    assign out_priority = out_priority_reg;
    assign entry_count  = entry_count_reg;
    assign queue_empty  = queue_empty_reg;

endmodule

`default_nettype wire
